// ===== hw/rtl/bpa_pkg.sv =====
// Shared constants, types and codes of the bitmap pool block allocator.
`default_nettype none

package bpa_pkg;

    // Sizing of the pool layout.
    localparam int NUM_POOLS       = 4;
    localparam int MAX_BLOCKS      = 64;
    localparam int MAX_BLOCK_WORDS = 1024;

    // Field widths.
    localparam int POOL_W   = 2;
    localparam int BLK_W    = 6;
    localparam int WORDS_W  = 11;
    localparam int COUNT_W  = 7;
    localparam int BYTES_W  = 13;
    localparam int NEED_W   = 12;
    localparam int OFFS_W   = 18;
    localparam int STATUS_W = 2;
    localparam int PROD_W   = 18;
    localparam int BASE_W   = 19;
    localparam int REM_W    = 18;
    localparam int SHIFT_W  = 3;
    localparam int CFG_IDX_W = 3;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOPOOL = 2'd2;

    // Configuration register map: block sizes first, then block counts.
    localparam logic [CFG_IDX_W-1:0] REG_WORDS0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORDS1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORDS2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORDS3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT3 = 3'd7;

    typedef logic [NUM_POOLS-1:0][WORDS_W-1:0] pool_words_t;
    typedef logic [NUM_POOLS-1:0][COUNT_W-1:0] pool_count_t;

    // Request to the shared arithmetic unit.
    typedef struct packed {
        logic [WORDS_W-1:0] block_words;
        logic [COUNT_W-1:0] factor;
        logic [REM_W-1:0]   rem;
        logic [SHIFT_W-1:0] shift;
    } unit_req_t;

    // Response of the shared arithmetic unit.
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [REM_W-1:0]  diff;
        logic              fits;
    } unit_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpa_cfg.sv =====
// Configuration registers of the pools, with saturation to the legal layout.
`default_nettype none

module bpa_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpa_pkg::WORDS_W-1:0]    cfg_data,
    output bpa_pkg::pool_words_t                eff_words,
    output bpa_pkg::pool_count_t                eff_count
);
    import bpa_pkg::*;

    logic [WORDS_W-1:0] words_reg [NUM_POOLS];
    logic [COUNT_W-1:0] count_reg [NUM_POOLS];

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg[0] <= WORDS_W'(1);
            words_reg[1] <= WORDS_W'(4);
            words_reg[2] <= WORDS_W'(16);
            words_reg[3] <= WORDS_W'(64);
            for (int i = 0; i < NUM_POOLS; i++)
            begin
                count_reg[i] <= COUNT_W'(MAX_BLOCKS);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WORDS0: words_reg[0] <= cfg_data;
                REG_WORDS1: words_reg[1] <= cfg_data;
                REG_WORDS2: words_reg[2] <= cfg_data;
                REG_WORDS3: words_reg[3] <= cfg_data;
                REG_COUNT0: count_reg[0] <= cfg_data[COUNT_W-1:0];
                REG_COUNT1: count_reg[1] <= cfg_data[COUNT_W-1:0];
                REG_COUNT2: count_reg[2] <= cfg_data[COUNT_W-1:0];
                REG_COUNT3: count_reg[3] <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes and counts; a zero block size disables the pool.
    always_comb
    begin
        for (int i = 0; i < NUM_POOLS; i++)
        begin
            eff_words[i] = (words_reg[i] > WORDS_W'(MAX_BLOCK_WORDS)) ?
                           WORDS_W'(MAX_BLOCK_WORDS) : words_reg[i];
            eff_count[i] = (count_reg[i] > COUNT_W'(MAX_BLOCKS)) ?
                           COUNT_W'(MAX_BLOCKS) : count_reg[i];
            if (words_reg[i] == '0)
            begin
                eff_count[i] = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_unit.sv =====
// Shared arithmetic unit: block size multiply and restoring-division trial step.
`default_nettype none

module bpa_unit (
    input  wire bpa_pkg::unit_req_t req,
    output bpa_pkg::unit_rsp_t      rsp
);
    import bpa_pkg::*;

    logic [REM_W:0] shifted;
    logic [REM_W:0] trial;

    // Size times count or size times block number.
    assign rsp.prod = PROD_W'(req.block_words) * PROD_W'(req.factor);

    // One quotient bit: try to take the shifted block size off the remainder.
    assign shifted  = (REM_W+1)'(req.block_words) << req.shift;
    assign trial    = {1'b0, req.rem} - shifted;
    assign rsp.fits = !trial[REM_W];
    assign rsp.diff = trial[REM_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_pool_block_allocator.sv =====
// Top level of the bitmap pool block allocator: sequencer and used-block maps.
//
// Usage. The block manages four pools of fixed-size blocks laid out one after
// another in a word memory. A command word is taken at a rising edge with start
// high and busy low: cmd selects allocate (request_bytes) or free
// (release_offset). busy stays high until the result has been shown.
// The result appears on status, pool_index, block_index and block_offset for
// exactly one cycle, marked by done; the receiver must take it then.
// Each pool visited takes a span multiply step, then a decision step.
// An allocate walks the pools, then computes the block offset, then shows the
// result. A free walks the pools, then runs a restoring division for the
// block index, then shows the result. The sequencer handles one command at a
// time, so the rate is set by this pool walk on the shared multiply and
// compare-subtract unit.
// Configuration words go in on cfg_valid/cfg_ready/cfg_index/cfg_data and
// must only be written while busy is low.
// Reset loads the default pool layout and marks every block free at once.
`default_nettype none

module bitmap_pool_block_allocator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           cmd,
    input  wire logic [bpa_pkg::BYTES_W-1:0]    request_bytes,
    input  wire logic [bpa_pkg::OFFS_W-1:0]     release_offset,
    output logic                                done,
    output logic [bpa_pkg::STATUS_W-1:0]        status,
    output logic [bpa_pkg::POOL_W-1:0]          pool_index,
    output logic [bpa_pkg::BLK_W-1:0]           block_index,
    output logic [bpa_pkg::OFFS_W-1:0]          block_offset,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpa_pkg::WORDS_W-1:0]    cfg_data
);
    import bpa_pkg::*;

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SPAN  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [POOL_W-1:0]  POOL_LAST = POOL_W'(NUM_POOLS - 1);
    localparam logic [SHIFT_W-1:0] SHIFT_TOP = SHIFT_W'(BLK_W - 1);

    pool_words_t eff_words;
    pool_count_t eff_count;
    unit_req_t   ureq;
    unit_rsp_t   ursp;

    logic [2:0]            state_reg, state_next;
    logic                  cmd_reg, cmd_next;
    logic [NEED_W-1:0]     need_reg, need_next;
    logic [OFFS_W-1:0]     offset_reg, offset_next;
    logic [POOL_W-1:0]     pool_reg, pool_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [PROD_W-1:0]     span_reg, span_next;
    logic                  found_reg, found_next;
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [SHIFT_W-1:0]    shift_reg, shift_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [POOL_W-1:0]     res_pool_reg, res_pool_next;
    logic [BLK_W-1:0]      res_blk_reg, res_blk_next;
    logic [OFFS_W-1:0]     res_offs_reg, res_offs_next;
    logic [MAX_BLOCKS-1:0] used_reg [NUM_POOLS];
    logic [MAX_BLOCKS-1:0] used_next [NUM_POOLS];

    logic [WORDS_W-1:0]    cur_words;
    logic [COUNT_W-1:0]    cur_count;
    logic [MAX_BLOCKS-1:0] free_vec;
    logic                  ff_found;
    logic [BLK_W-1:0]      ff_idx;
    logic [BASE_W-1:0]     off_ext;
    logic [BASE_W-1:0]     span_ext;
    logic                  hit;
    logic [BLK_W-1:0]      quot;
    logic [BASE_W-1:0]     place_sum;

    bpa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff_words (eff_words),
        .eff_count (eff_count)
    );

    bpa_unit u_unit (
        .req (ureq),
        .rsp (ursp)
    );

    assign cur_words = eff_words[pool_reg];
    assign cur_count = eff_count[pool_reg];

    // Operands of the shared unit follow the sequencer step.
    always_comb
    begin
        ureq.block_words = cur_words;
        ureq.factor      = (state_reg == S_PLACE) ? COUNT_W'(blk_reg) : cur_count;
        ureq.rem         = rem_reg;
        ureq.shift       = shift_reg;
    end

    // Lowest free block of the current pool within its block count.
    always_comb
    begin
        ff_found = 1'b0;
        ff_idx   = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            free_vec[i] = !used_reg[pool_reg][i] && (COUNT_W'(i) < cur_count);
        end
        for (int i = MAX_BLOCKS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                ff_found = 1'b1;
                ff_idx   = BLK_W'(i);
            end
        end
    end

    // Range check of a freed offset against the current pool.
    assign off_ext   = BASE_W'(offset_reg);
    assign span_ext  = BASE_W'(span_reg);
    assign hit       = (span_reg != '0) && (off_ext >= base_reg) &&
                       (off_ext < base_reg + span_ext);
    assign quot      = blk_reg | (BLK_W'(ursp.fits) << shift_reg);
    assign place_sum = base_reg + BASE_W'(ursp.prod);

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        need_next     = need_reg;
        offset_next   = offset_reg;
        pool_next     = pool_reg;
        base_next     = base_reg;
        span_next     = span_reg;
        found_next    = found_reg;
        blk_next      = blk_reg;
        rem_next      = rem_reg;
        shift_next    = shift_reg;
        status_next   = status_reg;
        res_pool_next = res_pool_reg;
        res_blk_next  = res_blk_reg;
        res_offs_next = res_offs_reg;
        for (int i = 0; i < NUM_POOLS; i++)
        begin
            used_next[i] = used_reg[i];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    need_next   = NEED_W'((14'(request_bytes) + 14'd3) >> 2);
                    offset_next = release_offset;
                    pool_next   = '0;
                    base_next   = '0;
                    state_next  = S_SPAN;
                end
            end
            S_SPAN:
            begin
                span_next  = ursp.prod;
                found_next = ff_found;
                blk_next   = ff_idx;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (cmd_reg == CMD_ALLOC && found_reg &&
                    NEED_W'(cur_words) >= need_reg)
                begin
                    used_next[pool_reg][blk_reg] = 1'b1;
                    state_next = S_PLACE;
                end
                else if (cmd_reg == CMD_FREE && hit)
                begin
                    rem_next   = REM_W'(off_ext - base_reg);
                    blk_next   = '0;
                    shift_next = SHIFT_TOP;
                    state_next = S_DIV;
                end
                else
                begin
                    base_next = base_reg + span_ext;
                    if (pool_reg == POOL_LAST)
                    begin
                        status_next   = (cmd_reg == CMD_ALLOC) ? ST_NOFIT : ST_NOPOOL;
                        res_pool_next = '0;
                        res_blk_next  = '0;
                        res_offs_next = '0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        pool_next  = pool_reg + POOL_W'(1);
                        state_next = S_SPAN;
                    end
                end
            end
            S_PLACE:
            begin
                status_next   = ST_OK;
                res_pool_next = pool_reg;
                res_blk_next  = blk_reg;
                res_offs_next = place_sum[OFFS_W-1:0];
                state_next    = S_DONE;
            end
            S_DIV:
            begin
                if (ursp.fits)
                begin
                    rem_next = ursp.diff;
                end
                blk_next = quot;
                if (shift_reg == '0)
                begin
                    used_next[pool_reg][quot] = 1'b0;
                    status_next   = ST_OK;
                    res_pool_next = pool_reg;
                    res_blk_next  = quot;
                    res_offs_next = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    shift_next = shift_reg - SHIFT_W'(1);
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and used-block maps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NUM_POOLS; i++)
            begin
                used_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            for (int i = 0; i < NUM_POOLS; i++)
            begin
                used_reg[i] <= used_next[i];
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        need_reg     <= need_next;
        offset_reg   <= offset_next;
        pool_reg     <= pool_next;
        base_reg     <= base_next;
        span_reg     <= span_next;
        found_reg    <= found_next;
        blk_reg      <= blk_next;
        rem_reg      <= rem_next;
        shift_reg    <= shift_next;
        status_reg   <= status_next;
        res_pool_reg <= res_pool_next;
        res_blk_reg  <= res_blk_next;
        res_offs_reg <= res_offs_next;
    end

    // Result word.
    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign status       = status_reg;
    assign pool_index   = res_pool_reg;
    assign block_index  = res_blk_reg;
    assign block_offset = res_offs_reg;

    // A command taken keeps the block busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command accepted but block not busy");

    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // A failed command reports no pool, block or offset.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |->
            pool_index == '0 && block_index == '0 && block_offset == '0)
        else $error("failed command reports a location");

    // A successful allocation leaves its block marked used.
    a_alloc_used: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OK && cmd_reg == CMD_ALLOC |->
            used_reg[pool_index][block_index])
        else $error("allocated block not marked used");

    // A successful free leaves its block marked free.
    a_free_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OK && cmd_reg == CMD_FREE |->
            !used_reg[pool_index][block_index])
        else $error("freed block still marked used");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench of the bitmap pool block allocator: allocate and free traffic.
`timescale 1ns / 1ps

module tb_top;

    import bpa_pkg::*;

    // One command word as the driver presents it.
    typedef struct packed {
        logic               cmd;
        logic [BYTES_W-1:0] bytes;
        logic [OFFS_W-1:0]  offs;
    } pool_op_t;

    // One result word as the block shows it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POOL_W-1:0]   pool;
        logic [BLK_W-1:0]    blk;
        logic [OFFS_W-1:0]   offset;
    } pool_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cmd;
    logic [BYTES_W-1:0]    request_bytes;
    logic [OFFS_W-1:0]     release_offset;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [POOL_W-1:0]     pool_index;
    logic [BLK_W-1:0]      block_index;
    logic [OFFS_W-1:0]     block_offset;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [WORDS_W-1:0]    cfg_data;

    // Shadow of the pool layout registers and of the used-block maps.
    logic [WORDS_W-1:0]    lay_words [NUM_POOLS];
    logic [COUNT_W-1:0]    lay_count [NUM_POOLS];
    logic [MAX_BLOCKS-1:0] used_map  [NUM_POOLS];

    pool_op_t     pending_ops [$];
    pool_result_t expected_results [$];

    int  n_issued   = 0;
    int  n_accepted = 0;
    int  n_checked  = 0;
    int  n_alloc    = 0;
    int  n_nofit    = 0;
    int  n_free     = 0;
    int  n_nopool   = 0;
    int  n_layouts  = 1;
    int  errors     = 0;
    int  gap_left   = 0;
    bit  no_idle    = 1'b0;

    bitmap_pool_block_allocator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .request_bytes  (request_bytes),
        .release_offset (release_offset),
        .done           (done),
        .status         (status),
        .pool_index     (pool_index),
        .block_index    (block_index),
        .block_offset   (block_offset),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Free-running clock, 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Block size as the block uses it: saturated at the largest size.
    function automatic int eff_words(input int p);
        int w;
        w = int'(lay_words[p]);
        return (w > MAX_BLOCK_WORDS) ? MAX_BLOCK_WORDS : w;
    endfunction

    // Block count as the block uses it: saturated, and zero for a disabled pool.
    function automatic int eff_count(input int p);
        int c;
        c = int'(lay_count[p]);
        if (c > MAX_BLOCKS)
            c = MAX_BLOCKS;
        if (eff_words(p) == 0)
            c = 0;
        return c;
    endfunction

    // Carry out one command on the shadow maps and return the result word it produces.
    function automatic pool_result_t serve_request(input logic op,
                                                   input logic [BYTES_W-1:0] bytes,
                                                   input logic [OFFS_W-1:0] offs);
        pool_result_t res;
        int base;
        int bw;
        int nb;
        int need;
        int b;
        int bytes_i;
        int offs_i;
        bit found;
        res     = '0;
        base    = 0;
        found   = 1'b0;
        bytes_i = int'(bytes);
        offs_i  = int'(offs);
        if (op == CMD_ALLOC)
        begin
            res.status = ST_NOFIT;
            need = (bytes_i + 3) / 4;
            for (int p = 0; p < NUM_POOLS && !found; p++)
            begin
                bw = eff_words(p);
                nb = eff_count(p);
                if (nb != 0 && bw >= need)
                begin
                    b = 0;
                    while (b < nb && used_map[p][b])
                        b++;
                    if (b < nb)
                    begin
                        used_map[p][b] = 1'b1;
                        found      = 1'b1;
                        res.status = ST_OK;
                        res.pool   = POOL_W'(p);
                        res.blk    = BLK_W'(b);
                        res.offset = OFFS_W'(base + bw * b);
                    end
                end
                base += bw * nb;
            end
        end
        else
        begin
            res.status = ST_NOPOOL;
            for (int p = 0; p < NUM_POOLS && !found; p++)
            begin
                bw = eff_words(p);
                nb = eff_count(p);
                if (bw * nb != 0 && offs_i >= base && offs_i < base + bw * nb)
                begin
                    // The owning pool holds the offset; clear the block it falls in.
                    b = (offs_i - base) / bw;
                    used_map[p][b] = 1'b0;
                    found      = 1'b1;
                    res.status = ST_OK;
                    res.pool   = POOL_W'(p);
                    res.blk    = BLK_W'(b);
                end
                base += bw * nb;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    task automatic queue_op(input logic op, input int bytes, input int offs);
        pool_op_t item;
        item.cmd   = op;
        item.bytes = BYTES_W'(bytes);
        item.offs  = OFFS_W'(offs);
        pending_ops.push_back(item);
    endtask

    // Write one layout register and mirror it once the channel takes the word.
    task automatic write_pool_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WORDS_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < REG_COUNT0)
            lay_words[idx] = data;
        else
            lay_count[idx - REG_COUNT0] = data[COUNT_W-1:0];
    endtask

    // Load a whole layout; the count words carry junk in their unused upper bits.
    task automatic load_layout(input pool_words_t w, input pool_count_t c,
                               input logic [WORDS_W-COUNT_W-1:0] junk);
        for (int p = 0; p < NUM_POOLS; p++)
            write_pool_reg(REG_WORDS0 + CFG_IDX_W'(p), w[p]);
        for (int p = 0; p < NUM_POOLS; p++)
            write_pool_reg(REG_COUNT0 + CFG_IDX_W'(p), {junk, c[p]});
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_layouts++;
    endtask

    // Wait until every command has been taken and answered and the block is idle.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_ops.size() != 0 || n_accepted != n_issued ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic: sizes near the pool block sizes, frees inside live pools.
    task automatic queue_random_ops(input int n, input int alloc_pct);
        int bw [NUM_POOLS];
        int nb [NUM_POOLS];
        int base [NUM_POOLS];
        int total;
        int p;
        int r;
        int k;
        int bytes;
        int offs;
        total = 0;
        for (int i = 0; i < NUM_POOLS; i++)
        begin
            bw[i]   = eff_words(i);
            nb[i]   = eff_count(i);
            base[i] = total;
            total  += bw[i] * nb[i];
        end
        repeat (n)
        begin
            p     = $urandom_range(0, NUM_POOLS - 1);
            r     = $urandom_range(0, 99);
            k     = $urandom_range(0, 9);
            bytes = $urandom_range(0, (1 << BYTES_W) - 1);
            offs  = $urandom_range(0, (1 << OFFS_W) - 1);
            if (r < alloc_pct)
            begin
                if (k == 1)
                    bytes = 0;
                else if (k == 2 || k == 3 || bw[p] == 0)
                    bytes = $urandom_range(0, 16);
                else if (k > 3)
                    bytes = $urandom_range((bw[p] - 1) * 4, bw[p] * 4 + 1);
                queue_op(CMD_ALLOC, bytes, offs);
            end
            else if (r < 92 && nb[p] != 0)
            begin
                offs = base[p] + $urandom_range(0, nb[p] - 1) * bw[p] +
                       $urandom_range(0, bw[p] - 1);
                queue_op(CMD_FREE, bytes, offs);
            end
            else
            begin
                // Offsets near and past the end of the last pool, or anywhere at all.
                if (k < 3)
                    offs = total - k;
                else if (k < 7 && total < (1 << OFFS_W))
                    offs = $urandom_range(total, (1 << OFFS_W) - 1);
                queue_op(CMD_FREE, bytes, offs);
            end
        end
    endtask

    // Driver: presents queued command words at the falling edge, with random idle bursts.
    always @(negedge clk)
    begin : drive_cmds
        pool_op_t item;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && n_accepted != n_issued)
        begin
            // The word on the ports has not been taken yet; hold it.
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left--;
        end
        else if (pending_ops.size() != 0)
        begin
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                start    <= 1'b0;
                gap_left = $urandom_range(0, 7);
            end
            else
            begin
                item = pending_ops.pop_front();
                cmd            <= item.cmd;
                request_bytes  <= item.bytes;
                release_offset <= item.offs;
                start          <= 1'b1;
                n_issued++;
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor: checks each shown result and predicts each command taken at this edge.
    always @(posedge clk)
    begin : watch_results
        pool_result_t got;
        pool_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got.status = status;
                got.pool   = pool_index;
                got.blk    = block_index;
                got.offset = block_offset;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, status %0d pool %0d block %0d offset %0d",
                             $time, got.status, got.pool, got.blk, got.offset);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("pool_index", int'(want.pool), int'(got.pool));
                    check_field("block_index", int'(want.blk), int'(got.blk));
                    check_field("block_offset", int'(want.offset), int'(got.offset));
                    n_checked++;
                end
            end
            if (start && !busy)
            begin
                want = serve_request(cmd, request_bytes, release_offset);
                expected_results.push_back(want);
                n_accepted++;
                if (cmd == CMD_ALLOC)
                begin
                    n_alloc++;
                    if (want.status == ST_NOFIT)
                        n_nofit++;
                end
                else
                begin
                    n_free++;
                    if (want.status == ST_NOPOOL)
                        n_nopool++;
                end
            end
        end
    end

    // Main sequence: reset, directed commands, then random traffic over several layouts.
    initial
    begin : run_seq
        pool_words_t w;
        pool_count_t c;
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = CMD_ALLOC;
        request_bytes  = '0;
        release_offset = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_WORDS0;
        cfg_data       = '0;
        lay_words = '{11'd1, 11'd4, 11'd16, 11'd64};
        lay_count = '{7'd64, 7'd64, 7'd64, 7'd64};
        for (int p = 0; p < NUM_POOLS; p++)
            used_map[p] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset layout: zero bytes, each pool's size edge,
        // requests too large for any pool, double free, mid-block free, pool ends.
        queue_op(CMD_ALLOC, 0, 0);
        queue_op(CMD_ALLOC, 1, 0);
        queue_op(CMD_ALLOC, 4, 0);
        queue_op(CMD_ALLOC, 5, 0);
        queue_op(CMD_ALLOC, 16, 0);
        queue_op(CMD_ALLOC, 64, 0);
        queue_op(CMD_ALLOC, 256, 0);
        queue_op(CMD_ALLOC, 257, 0);
        queue_op(CMD_ALLOC, 4096, 0);
        queue_op(CMD_ALLOC, 8191, 262143);
        queue_op(CMD_FREE, 0, 0);
        queue_op(CMD_FREE, 0, 0);
        queue_op(CMD_FREE, 8191, 65);
        queue_op(CMD_FREE, 0, 63);
        queue_op(CMD_FREE, 0, 1343);
        queue_op(CMD_FREE, 0, 1344);
        queue_op(CMD_FREE, 0, 5439);
        queue_op(CMD_FREE, 0, 5440);
        queue_op(CMD_FREE, 0, 262143);
        queue_op(CMD_ALLOC, 0, 0);
        queue_random_ops(106, 55);
        wait_drained();

        // Tiny pools that fill up quickly.
        w = {11'd8, 11'd5, 11'd3, 11'd2};
        c = {7'd1, 7'd4, 7'd2, 7'd3};
        load_layout(w, c, 4'h0);
        queue_random_ops(106, 60);
        wait_drained();

        // Extremes: disabled pool, oversize words, exact maximum, zero and oversize counts.
        w = {11'd1, 11'd1024, 11'd2047, 11'd0};
        c = {7'd64, 7'd0, 7'd127, 7'd64};
        load_layout(w, c, 4'hF);
        queue_random_ops(106, 50);
        wait_drained();

        // Largest layout: the pools cover the whole offset range.
        w = {11'd1024, 11'd1024, 11'd1024, 11'd1024};
        c = {7'd64, 7'd64, 7'd64, 7'd64};
        load_layout(w, c, 4'h5);
        queue_random_ops(106, 65);
        wait_drained();

        // Random layouts, mostly small; the last one runs without idle cycles.
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int p = 0; p < NUM_POOLS; p++)
            begin
                case ($urandom_range(0, 9))
                    0:       w[p] = '0;
                    1:       w[p] = WORDS_W'($urandom_range(MAX_BLOCK_WORDS + 1,
                                                            (1 << WORDS_W) - 1));
                    2:       w[p] = WORDS_W'(MAX_BLOCK_WORDS);
                    default: w[p] = WORDS_W'($urandom_range(1, 64));
                endcase
                case ($urandom_range(0, 9))
                    0:       c[p] = '0;
                    1:       c[p] = COUNT_W'($urandom_range(MAX_BLOCKS + 1,
                                                            (1 << COUNT_W) - 1));
                    2:       c[p] = COUNT_W'(MAX_BLOCKS);
                    default: c[p] = COUNT_W'($urandom_range(1, 12));
                endcase
            end
            load_layout(w, c, (WORDS_W-COUNT_W)'($urandom_range(0, 15)));
            no_idle = (ph == 3);
            queue_random_ops(106, $urandom_range(40, 70));
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Ran %0d commands over %0d pool layouts, %0d results checked.",
                 n_accepted, n_layouts, n_checked);
        $display("Allocates: %0d (%0d found no block). Frees: %0d (%0d outside every pool).",
                 n_alloc, n_nofit, n_free, n_nopool);
        if (errors == 0)
            $display("** bitmap_pool_block_allocator: PASSED **");
        else
            $display("** bitmap_pool_block_allocator: FAILED **");
        $finish;
    end

    // Watchdog: the run is far shorter than this even with every command at its slowest.
    initial
    begin : watchdog
        #3_000_000;
        $display("%0t: timeout with %0d results still expected", $time, expected_results.size());
        $display("** bitmap_pool_block_allocator: FAILED **");
        $finish;
    end

endmodule
